>>> rtl/core/peq_pkg.sv
// shared types and constants for the ps2 input event queue
`timescale 1ns / 1ps
`default_nettype none

package peq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ACT_KEY   = 3'd0,
      ACT_MOUSE = 3'd1,
      ACT_PUSH  = 3'd2,
      ACT_POP   = 3'd3,
      ACT_CLEAR = 3'd4
   } peq_action_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_PENDING = 3'd1,
      ST_REJECT  = 3'd2,
      ST_FULL    = 3'd3,
      ST_EMPTY   = 3'd4
   } peq_status_type;

   localparam logic [7:0] KEY_PREFIX   = 8'he0;
   localparam logic [6:0] KEY_LAST     = 7'd83;
   localparam logic [6:0] ARROW_UP     = 7'h48;
   localparam logic [6:0] ARROW_LEFT   = 7'h4b;
   localparam logic [6:0] ARROW_RIGHT  = 7'h4d;
   localparam logic [6:0] ARROW_DOWN   = 7'h50;
   localparam logic [1:0] PKT_LAST_POS = 2'd2;

   typedef struct packed {
      logic [2:0]         action;
      logic [7:0]         data_byte;
      logic [31:0]        timestamp;
      logic signed [31:0] push_x;
      logic signed [31:0] push_y;
      logic [15:0]        push_code;
      logic [1:0]         push_type;
      logic               push_pressed;
   } peq_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        out_time;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic [15:0]        out_code;
      logic               out_kind;
      logic               out_pressed;
      logic [5:0]         fill_level;
   } peq_rsp_type;

   typedef struct packed {
      logic [31:0] ev_time;
      logic [31:0] ev_x;
      logic [31:0] ev_y;
      logic [15:0] ev_code;
      logic        ev_kind;
      logic        ev_pressed;
   } peq_event_type;

endpackage

`default_nettype wire

>>> rtl/core/ps2_input_event_queue.sv
// ps2 keyboard/mouse decoder feeding a timestamped event fifo
`timescale 1ns / 1ps
`default_nettype none

// One command is taken on any cycle with start high; busy never rises, so a
// command can be issued every clock. Each command gives exactly one result,
// on rsp_valid for one cycle, in the cycle after it was taken: the decode and
// the fifo write or read happen in the accept cycle, and a pop's event comes
// out of the registered read port of the event memory. The receiver must take
// every result as it appears. Fields of a result that does not pop an event
// are zero. The event memory is not cleared at reset; the fill count keeps
// unwritten entries from ever being read.
module ps2_input_event_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  peq_pkg::peq_req_type req_data,
   output logic                 rsp_valid,
   output peq_pkg::peq_rsp_type rsp_data
);
   import peq_pkg::*;

   peq_event_type mem [QUEUE_DEPTH];
   peq_event_type rd_ff;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             prefix_ff, prefix_in;
   logic [7:0]       pkt0_ff, pkt0_in;
   logic [7:0]       pkt1_ff, pkt1_in;
   logic [1:0]       pos_ff, pos_in;
   logic             rsp_valid_ff;
   peq_status_type   status_ff, status_in;
   logic [5:0]       fill_ff;
   logic             pop_ff;

   logic           accept;
   logic           want_enq;
   peq_event_type  enq_event;
   logic           wr_en;
   logic           rd_en;
   logic           full;
   logic [6:0]     key_code;
   logic           key_arrow;
   logic [31:0]    sx_byte1;
   logic [31:0]    sx_byte;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));

   assign key_code  = req_data.data_byte[6:0];
   assign key_arrow = (key_code == ARROW_UP) || (key_code == ARROW_LEFT) ||
                      (key_code == ARROW_RIGHT) || (key_code == ARROW_DOWN);
   assign sx_byte1  = {{24{pkt1_ff[7]}}, pkt1_ff};
   assign sx_byte   = {{24{req_data.data_byte[7]}}, req_data.data_byte};

   always_comb begin
      prefix_in = prefix_ff;
      pkt0_in   = pkt0_ff;
      pkt1_in   = pkt1_ff;
      pos_in    = pos_ff;
      status_in = ST_REJECT;
      want_enq  = 1'b0;
      rd_en     = 1'b0;
      enq_event = '0;
      enq_event.ev_time = req_data.timestamp;
      case (req_data.action)
         ACT_KEY: begin
            if (req_data.data_byte == KEY_PREFIX) begin
               prefix_in = 1'b1;
               status_in = ST_PENDING;
            end else begin
               prefix_in = 1'b0;
               if (key_code == 7'd0 || key_code > KEY_LAST) begin
                  status_in = ST_REJECT;
               end else if (prefix_ff && !key_arrow) begin
                  status_in = ST_REJECT;
               end else begin
                  want_enq             = 1'b1;
                  enq_event.ev_code    = {9'd0, key_code};
                  enq_event.ev_pressed = !req_data.data_byte[7];
               end
            end
         end
         ACT_MOUSE: begin
            if (pos_ff == 2'd0 && !req_data.data_byte[3]) begin
               status_in = ST_REJECT;
            end else if (pos_ff < PKT_LAST_POS) begin
               if (pos_ff[0]) begin
                  pkt1_in = req_data.data_byte;
               end else begin
                  pkt0_in = req_data.data_byte;
               end
               pos_in    = pos_ff + 2'd1;
               status_in = ST_PENDING;
            end else begin
               pos_in = 2'd0;
               // overflow bits in the header drop the whole packet
               if (pkt0_ff[7:6] != 2'b00) begin
                  status_in = ST_REJECT;
               end else begin
                  want_enq             = 1'b1;
                  enq_event.ev_x       = sx_byte1;
                  enq_event.ev_y       = 32'd0 - sx_byte;
                  enq_event.ev_code    = {13'd0, pkt0_ff[2:0]};
                  enq_event.ev_kind    = 1'b1;
                  enq_event.ev_pressed = pkt0_ff[0];
               end
            end
         end
         ACT_PUSH: begin
            if (req_data.push_type[1]) begin
               status_in = ST_REJECT;
            end else begin
               want_enq             = 1'b1;
               enq_event.ev_x       = req_data.push_x;
               enq_event.ev_y       = req_data.push_y;
               enq_event.ev_code    = req_data.push_code;
               enq_event.ev_kind    = req_data.push_type[0];
               enq_event.ev_pressed = req_data.push_pressed;
            end
         end
         ACT_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en     = 1'b1;
               status_in = ST_DONE;
            end
         end
         ACT_CLEAR: begin
            status_in = ST_DONE;
         end
         default: begin
            status_in = ST_REJECT;
         end
      endcase
      // decoder state still advances when the event is dropped on full
      if (want_enq) begin
         status_in = full ? ST_FULL : ST_DONE;
      end
   end

   assign wr_en = accept && want_enq && !full;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_data.action == ACT_CLEAR) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
         end else if (wr_en) begin
            tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end else if (rd_en) begin
            head_in  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= enq_event;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && rd_en) begin
         rd_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         prefix_ff    <= 1'b0;
         pkt0_ff      <= '0;
         pkt1_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pop_ff       <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         if (accept) begin
            prefix_ff <= prefix_in;
            pkt0_ff   <= pkt0_in;
            pkt1_ff   <= pkt1_in;
            pos_ff    <= pos_in;
            pop_ff    <= rd_en;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         fill_ff   <= 6'(count_in);
      end
   end

   always_comb begin
      rsp_data = '0;
      rsp_data.status     = status_ff;
      rsp_data.fill_level = fill_ff;
      if (pop_ff) begin
         rsp_data.out_time    = rd_ff.ev_time;
         rsp_data.out_x       = rd_ff.ev_x;
         rsp_data.out_y       = rd_ff.ev_y;
         rsp_data.out_code    = rd_ff.ev_code;
         rsp_data.out_kind    = rd_ff.ev_kind;
         rsp_data.out_pressed = rd_ff.ev_pressed;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_one_beat_per_cmd: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("command without a result beat");

   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result beat without a command");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   a_full_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         rsp_data.fill_level == 6'(QUEUE_DEPTH))
      else $error("queue full reported below depth");

endmodule

`default_nettype wire
